### rtl/wpb_pkg.sv
// Shared types, constants and helper functions for the WAV/PCM base64 stream encoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package wpb_pkg;

    // Field widths fixed by the interface.
    localparam int PCM_SIZE_W = 21;
    localparam int BYTE_W     = 8;

    // Largest clip size that is accepted.
    localparam logic [PCM_SIZE_W-1:0] PCM_MAX_BYTES = 21'd1048576;

    // Default depth of the queue between front and back.
    localparam int CMD_DEPTH_DEF = 4;

    // WAV header constants.
    localparam logic [5:0]  HDR_LEN         = 6'd44;
    localparam logic [31:0] RIFF_EXTRA      = 32'd36;
    localparam logic [31:0] FMT_CHUNK_LEN   = 32'd16;
    localparam logic [31:0] SAMPLE_RATE     = 32'd16000;
    localparam logic [31:0] BYTE_RATE       = 32'd32000;
    localparam logic [7:0]  BITS_PER_SAMPLE = 8'd16;
    localparam logic [7:0]  BLOCK_ALIGN     = 8'd2;
    localparam logic [7:0]  PCM_FORMAT      = 8'd1;
    localparam logic [7:0]  NUM_CHANNELS    = 8'd1;

    // Padding character.
    localparam logic [7:0] CH_PAD = 8'h3D;

    // What the front has decided about one accepted byte.
    typedef enum logic [1:0] {
        K_ERR,
        K_HDR,
        K_DATA,
        K_LAST
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    // Base64 alphabet lookup for one sextet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        priority if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // One byte of the 44-byte little-endian WAV header.
    function automatic logic [7:0] hdr_byte(input logic [5:0] idx,
                                            input logic [PCM_SIZE_W-1:0] pcm);
        logic [31:0] riff;
        logic [31:0] dsz;
        logic [7:0]  b;
        riff = {{(32-PCM_SIZE_W){1'b0}}, pcm} + RIFF_EXTRA;
        dsz  = {{(32-PCM_SIZE_W){1'b0}}, pcm};
        unique case (idx)
            6'd0:    b = 8'h52;   // "RIFF"
            6'd1:    b = 8'h49;
            6'd2:    b = 8'h46;
            6'd3:    b = 8'h46;
            6'd4:    b = riff[7:0];
            6'd5:    b = riff[15:8];
            6'd6:    b = riff[23:16];
            6'd7:    b = riff[31:24];
            6'd8:    b = 8'h57;   // "WAVEfmt "
            6'd9:    b = 8'h41;
            6'd10:   b = 8'h56;
            6'd11:   b = 8'h45;
            6'd12:   b = 8'h66;
            6'd13:   b = 8'h6D;
            6'd14:   b = 8'h74;
            6'd15:   b = 8'h20;
            6'd16:   b = FMT_CHUNK_LEN[7:0];
            6'd20:   b = PCM_FORMAT;
            6'd22:   b = NUM_CHANNELS;
            6'd24:   b = SAMPLE_RATE[7:0];
            6'd25:   b = SAMPLE_RATE[15:8];
            6'd28:   b = BYTE_RATE[7:0];
            6'd29:   b = BYTE_RATE[15:8];
            6'd32:   b = BLOCK_ALIGN;
            6'd34:   b = BITS_PER_SAMPLE;
            6'd36:   b = 8'h64;   // "data"
            6'd37:   b = 8'h61;
            6'd38:   b = 8'h74;
            6'd39:   b = 8'h61;
            6'd40:   b = dsz[7:0];
            6'd41:   b = dsz[15:8];
            6'd42:   b = dsz[23:16];
            6'd43:   b = dsz[31:24];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/wpb_front.sv
// Front end of the encoder: holds the clip size and the byte count, classifies each beat.
// Depends on wpb_pkg.
`timescale 1ns / 1ps

module wpb_front import wpb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [PCM_SIZE_W-1:0] i_cfg_wdata,
    input  logic                  i_push,
    input  logic [BYTE_W-1:0]     i_pcm_byte,
    input  logic                  i_full,
    output logic                  o_wr,
    output t_cmd                  o_cmd,
    output logic [PCM_SIZE_W-1:0] o_clip_len,
    output logic                  o_clear
);

    logic [PCM_SIZE_W-1:0] r_clip_len;
    logic [PCM_SIZE_W-1:0] r_bytes_seen;
    logic [PCM_SIZE_W-1:0] n_bytes_seen;
    logic                  size_ok;
    logic                  is_err;
    logic                  accept;

    // Classify the incoming beat against the configured clip size.
    always_comb begin
        size_ok = (r_clip_len != '0) && !r_clip_len[0] && (r_clip_len <= PCM_MAX_BYTES);
        is_err  = !size_ok || (r_bytes_seen >= r_clip_len);
        n_bytes_seen = r_bytes_seen + PCM_SIZE_W'(1);
        accept  = i_push && !i_full;
        o_cmd.data = i_pcm_byte;
        priority if (is_err) begin
            o_cmd.kind = K_ERR;
        end else if (r_bytes_seen == '0) begin
            o_cmd.kind = K_HDR;
        end else if (n_bytes_seen == r_clip_len) begin
            o_cmd.kind = K_LAST;
        end else begin
            o_cmd.kind = K_DATA;
        end
    end

    assign o_wr       = accept;
    assign o_clip_len = r_clip_len;
    assign o_clear    = i_cfg_we;

    // Size register and byte count; a size write restarts the stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_len   <= '0;
            r_bytes_seen <= '0;
        end else if (i_cfg_we) begin
            r_clip_len   <= i_cfg_wdata;
            r_bytes_seen <= '0;
        end else if (accept && !is_err) begin
            r_bytes_seen <= n_bytes_seen;
        end
    end

endmodule

### rtl/wpb_cmd_fifo.sv
// Short command queue that decouples the front end from the encoding back end.
// Depends on wpb_pkg.
`timescale 1ns / 1ps

module wpb_cmd_fifo import wpb_pkg::*; #(
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // The count never runs past the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("command queue count exceeds depth");

    // An empty queue has both pointers together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("command queue pointers disagree with count");

    // The back end only takes a command that is there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid)
        else $error("command queue read while empty");

endmodule

### rtl/wpb_back.sv
// Back end of the encoder: expands commands into header and PCM bytes and emits base64 text.
// Depends on wpb_pkg.
`timescale 1ns / 1ps

module wpb_back import wpb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic [PCM_SIZE_W-1:0] i_clip_len,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_text_char,
    output logic                  o_last_char,
    output logic                  o_size_error
);

    typedef enum logic [1:0] {
        S_TAKE,
        S_HDR,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [15:0] r_group;
    logic [1:0]  r_fill;
    logic [5:0]  r_hidx;
    logic [7:0]  r_hold;
    logic [23:0] r_triple;
    logic [1:0]  r_pad;
    logic        r_last;
    logic [1:0]  r_k;
    logic        r_ret_hdr;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;
    logic        r_out_err;

    logic        out_free;
    logic        out_load;
    logic [7:0]  fd_byte;
    logic        fd_last_in;
    logic        fd_emit;
    logic [23:0] fd_triple;
    logic [1:0]  fd_pad;
    logic [15:0] fd_group;
    logic [1:0]  fd_fill;
    logic [5:0]  sextet;
    logic [7:0]  emit_char;

    assign out_free     = !r_out_valid || i_pop;
    assign o_empty      = !r_out_valid;
    assign o_text_char  = r_out_char;
    assign o_last_char  = r_out_last;
    assign o_size_error = r_out_err;

    // A command is taken whenever the sequencer waits for one; an error beat also needs the output slot.
    assign o_cmd_pop = (r_state == S_TAKE) && i_cmd_valid
                       && ((i_cmd.kind != K_ERR) || out_free);

    // The output register loads on an error beat or on each character of a run.
    assign out_load = !i_clear
                      && ((o_cmd_pop && (i_cmd.kind == K_ERR))
                          || ((r_state == S_EMIT) && out_free));

    // Byte source: header bytes and the held PCM byte, or the command byte.
    always_comb begin
        if (r_state == S_HDR) begin
            fd_byte = (r_hidx == HDR_LEN) ? r_hold : hdr_byte(r_hidx, i_clip_len);
        end else begin
            fd_byte = i_cmd.data;
        end
        fd_last_in = (r_state == S_TAKE) && (i_cmd.kind == K_LAST);
    end

    // Group assembly: a full group, or the last byte, starts a four-character run.
    always_comb begin
        fd_emit   = 1'b0;
        fd_triple = {r_group, fd_byte};
        fd_pad    = 2'd0;
        fd_group  = '0;
        fd_fill   = 2'd0;
        priority if (r_fill == 2'd2) begin
            fd_emit = 1'b1;
        end else if (fd_last_in) begin
            fd_emit = 1'b1;
            if (r_fill == 2'd1) begin
                fd_triple = {r_group[7:0], fd_byte, 8'h00};
                fd_pad    = 2'd1;
            end else begin
                fd_triple = {fd_byte, 16'h0000};
                fd_pad    = 2'd2;
            end
        end else begin
            fd_group = {r_group[7:0], fd_byte};
            fd_fill  = r_fill + 2'd1;
        end
    end

    // Character of the current position in the run.
    always_comb begin
        unique case (r_k)
            2'd0: sextet = r_triple[23:18];
            2'd1: sextet = r_triple[17:12];
            2'd2: sextet = r_triple[11:6];
            2'd3: sextet = r_triple[5:0];
        endcase
        if (({1'b0, r_k} + {1'b0, r_pad}) > 3'd3) begin
            emit_char = CH_PAD;
        end else begin
            emit_char = b64_char(sextet);
        end
    end

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_TAKE;
            r_group     <= '0;
            r_fill      <= '0;
            r_hidx      <= '0;
            r_k         <= '0;
            r_ret_hdr   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_clear) begin
                r_state <= S_TAKE;
                r_group <= '0;
                r_fill  <= '0;
                r_k     <= '0;
            end else begin
                unique case (r_state)
                    S_TAKE: begin
                        if (o_cmd_pop) begin
                            unique case (i_cmd.kind)
                                K_ERR: begin
                                    r_out_char  <= 8'h00;
                                    r_out_last  <= 1'b0;
                                    r_out_err   <= 1'b1;
                                end
                                K_HDR: begin
                                    r_hold  <= i_cmd.data;
                                    r_hidx  <= '0;
                                    r_group <= '0;
                                    r_fill  <= '0;
                                    r_state <= S_HDR;
                                end
                                K_DATA, K_LAST: begin
                                    r_group  <= fd_group;
                                    r_fill   <= fd_fill;
                                    r_triple <= fd_triple;
                                    r_pad    <= fd_pad;
                                    r_last   <= fd_last_in;
                                    if (fd_emit) begin
                                        r_ret_hdr <= 1'b0;
                                        r_state   <= S_EMIT;
                                    end
                                end
                            endcase
                        end
                    end
                    S_HDR: begin
                        r_group  <= fd_group;
                        r_fill   <= fd_fill;
                        r_triple <= fd_triple;
                        r_pad    <= fd_pad;
                        r_last   <= 1'b0;
                        r_hidx   <= r_hidx + 6'd1;
                        if (fd_emit) begin
                            r_ret_hdr <= (r_hidx != HDR_LEN);
                            r_state   <= S_EMIT;
                        end else if (r_hidx == HDR_LEN) begin
                            r_state <= S_TAKE;
                        end
                    end
                    S_EMIT: begin
                        if (out_free) begin
                            r_out_char  <= emit_char;
                            r_out_last  <= r_last && (r_k == 2'd3);
                            r_out_err   <= 1'b0;
                            r_k         <= r_k + 2'd1;
                            if (r_k == 2'd3) begin
                                r_state <= r_ret_hdr ? S_HDR : S_TAKE;
                            end
                        end
                    end
                    default: r_state <= S_TAKE;
                endcase
            end
        end
    end

    // At most two bytes ever wait in the open group.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("open group holds three bytes");

    // An error beat carries no character and no end mark.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> ((r_out_char == 8'h00) && !r_out_last))
        else $error("error beat carries character data");

    // The character index only moves inside a run.
    a_k_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EMIT) |-> (r_k == 2'd0))
        else $error("character index left mid-run");

    // The header walk never passes the held PCM byte.
    a_hidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |-> (r_hidx <= HDR_LEN))
        else $error("header index out of range");

endmodule

### rtl/wav_pcm_base64_stream.sv
// Top level of the WAV/PCM base64 stream encoder: front end, command queue and back end.
// Depends on wpb_pkg, wpb_front, wpb_cmd_fifo and wpb_back.
//
//   channel   | ports                                        | handshake
//   ----------+----------------------------------------------+-------------------------
//   pcm in    | i_pcm_byte                                   | push / full
//   text out  | o_text_char, o_last_char, o_size_error       | empty / pop
//   config    | i_cfg_wdata (clip size)                      | i_cfg_we, no wait
//
// In steady state each three-byte group is taken from the queue one byte at a time, and
// then its four characters are sent through the single output register; no byte is
// taken while a run is being sent. The first byte of a clip walks the 44 header bytes
// as well. Reset is synchronous and active low and clears the size to zero; a size write
// restarts the stream. The command queue lets input keep arriving while pop stalls.
`timescale 1ns / 1ps

module wav_pcm_base64_stream import wpb_pkg::*; #(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [PCM_SIZE_W-1:0] i_cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic [BYTE_W-1:0]     i_pcm_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_text_char,
    output logic                  o_last_char,
    output logic                  o_size_error
);

    logic                  wr;
    t_cmd                  wr_cmd;
    logic [PCM_SIZE_W-1:0] clip_len;
    logic                  clear;
    logic                  cmd_valid;
    t_cmd                  rd_cmd;
    logic                  cmd_pop;

    // Classification of incoming beats.
    wpb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_pcm_byte  (i_pcm_byte),
        .i_full      (full),
        .o_wr        (wr),
        .o_cmd       (wr_cmd),
        .o_clip_len  (clip_len),
        .o_clear     (clear)
    );

    // Queue between the two halves.
    wpb_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_cmd   (wr_cmd),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (rd_cmd)
    );

    // Encoding and character output.
    wpb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (clear),
        .i_clip_len   (clip_len),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (rd_cmd),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_text_char  (o_text_char),
        .o_last_char  (o_last_char),
        .o_size_error (o_size_error)
    );

endmodule
